/* design/zscore_standardizer_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the z-score standardiser.
// ---------------------------------------------------------------------------
`ifndef ZSCORE_STANDARDIZER_CORE_MACROS_SVH
`define ZSCORE_STANDARDIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ZS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ZS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ZS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/zs_pkg.sv */
// ---------------------------------------------------------------------------
// zs_pkg
// Shared types and codes for the z-score standardiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package zs_pkg;
    localparam logic [1:0] CMD_TRAIN = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_NORM = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_FEW = 3'd2;
    localparam logic [2:0] ST_UNFIT = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;

    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_SUM_CLR = 4'd1;
    localparam logic [3:0] OP_SUM_ADD = 4'd2;
    localparam logic [3:0] OP_DIV_START = 4'd3;
    localparam logic [3:0] OP_DIV_STEP = 4'd4;
    localparam logic [3:0] OP_MEAN_WR = 4'd5;
    localparam logic [3:0] OP_SQ_MUL = 4'd6;
    localparam logic [3:0] OP_SQ_ADD = 4'd7;
    localparam logic [3:0] OP_VAR_START = 4'd8;
    localparam logic [3:0] OP_SQRT_START = 4'd9;
    localparam logic [3:0] OP_SQRT_STEP = 4'd10;
    localparam logic [3:0] OP_SD_WR = 4'd11;
    localparam logic [3:0] OP_NORM_START = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } ctl_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic sd_zero;
    } sts_t;
endpackage

/* design/zs_ram.sv */
// ---------------------------------------------------------------------------
// zs_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module zs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* design/zs_datapath.sv */
// ---------------------------------------------------------------------------
// zs_datapath
// Sum, mean/variance/normalise divider, square root and statistics tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module zs_datapath #(
    parameter int DIMS = 8,
    parameter int FRAC_BITS = 16,
    parameter int CW = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  zs_pkg::ctl_t            ctl,
    input  logic [$clog2(DIMS+1)-1:0] dim,
    input  logic [CW-1:0]           n,
    input  logic signed [31:0]      sample,
    input  logic signed [31:0]      value,
    output zs_pkg::sts_t            sts,
    output logic signed [31:0]      norm
);
    localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;

    logic signed [31:0] mean_reg [DIMS];
    logic [31:0]        sd_reg [DIMS];
    logic signed [63:0] sum_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        sq_reg;
    logic signed [32:0] dev_reg;
    // divider
    logic [63:0]        dq_reg;
    logic [63:0]        drem_reg;
    logic [63:0]        dden_reg;
    logic [6:0]         dcnt_reg;
    logic               dneg_reg;
    logic               dbusy_reg;
    // square root
    logic [63:0]        sv_reg;
    logic [63:0]        sr_reg;
    logic [63:0]        sb_reg;
    logic               sbusy_reg;
    logic [DW-1:0]      di;

    logic [64:0]        rem_sh;
    logic [63:0]        mag64;
    logic [32:0]        dmag;
    logic signed [32:0] ndev;
    logic [63:0]        sqsum;
    logic [32:0]        sqm;

    assign di = dim[DW-1:0];
    assign rem_sh = {drem_reg, dq_reg[63]};
    assign ndev = 33'(value) - 33'(mean_reg[di]);
    assign dmag = ndev[32] ? 33'(-ndev) : 33'(ndev);
    assign mag64 = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
    assign sqsum = acc_reg + sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIMS; i++)
            begin
                mean_reg[i] <= '0;
                sd_reg[i] <= '0;
            end
            sum_reg <= '0;
            acc_reg <= '0;
            dev_reg <= '0;
            dq_reg <= '0;
            drem_reg <= '0;
            dden_reg <= '0;
            dneg_reg <= 1'b0;
            sv_reg <= '0;
            sr_reg <= '0;
            sb_reg <= '0;
            dbusy_reg <= 1'b0;
            sbusy_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            unique case (ctl.op)
                zs_pkg::OP_SUM_CLR:
                begin
                    sum_reg <= '0;
                    acc_reg <= '0;
                end
                zs_pkg::OP_SUM_ADD: sum_reg <= sum_reg + 64'(sample);
                zs_pkg::OP_DIV_START:
                begin
                    dq_reg <= mag64;
                    drem_reg <= '0;
                    dden_reg <= 64'(n);
                    dneg_reg <= sum_reg[63];
                    dcnt_reg <= 7'd64;
                    dbusy_reg <= 1'b1;
                end
                zs_pkg::OP_VAR_START:
                begin
                    dq_reg <= acc_reg;
                    drem_reg <= '0;
                    dden_reg <= 64'(n - CW'(1));
                    dneg_reg <= 1'b0;
                    dcnt_reg <= 7'd64;
                    dbusy_reg <= 1'b1;
                end
                zs_pkg::OP_NORM_START:
                begin
                    dq_reg <= 64'(dmag) << FRAC_BITS;
                    drem_reg <= '0;
                    dden_reg <= 64'(sd_reg[di]);
                    dneg_reg <= ndev[32];
                    dev_reg <= ndev;
                    dcnt_reg <= 7'd64;
                    dbusy_reg <= 1'b1;
                end
                zs_pkg::OP_DIV_STEP:
                begin
                    if (dcnt_reg != '0)
                    begin
                        if (rem_sh >= {1'b0, dden_reg})
                        begin
                            drem_reg <= 64'(rem_sh - {1'b0, dden_reg});
                            dq_reg <= {dq_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= rem_sh[63:0];
                            dq_reg <= {dq_reg[62:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 7'd1;
                    end
                    else
                    begin
                        dbusy_reg <= 1'b0;
                    end
                end
                zs_pkg::OP_MEAN_WR:
                begin
                    mean_reg[di] <= dneg_reg ? 32'(-dq_reg) : dq_reg[31:0];
                end
                zs_pkg::OP_SQ_MUL:
                begin
                    dev_reg <= 33'(sample) - 33'(mean_reg[di]);
                end
                zs_pkg::OP_SQ_ADD:
                begin
                    acc_reg <= (sqsum < acc_reg) ? '1 : sqsum;
                end
                zs_pkg::OP_SQRT_START:
                begin
                    sv_reg <= dq_reg;
                    sr_reg <= '0;
                    sb_reg <= 64'h4000_0000_0000_0000;
                    sbusy_reg <= 1'b1;
                end
                zs_pkg::OP_SQRT_STEP:
                begin
                    if (sb_reg != '0)
                    begin
                        if (sv_reg >= sr_reg + sb_reg)
                        begin
                            sv_reg <= sv_reg - (sr_reg + sb_reg);
                            sr_reg <= (sr_reg >> 1) + sb_reg;
                        end
                        else
                        begin
                            sr_reg <= sr_reg >> 1;
                        end
                        sb_reg <= sb_reg >> 2;
                    end
                    else
                    begin
                        sbusy_reg <= 1'b0;
                    end
                end
                zs_pkg::OP_SD_WR: sd_reg[di] <= sr_reg[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // squared deviation registered after the subtract
    assign sqm = dev_reg[32] ? 33'(-dev_reg) : 33'(dev_reg);
    always_ff @(posedge clk)
    begin
        sq_reg <= 64'(sqm) * 64'(sqm);
    end

    assign sts.div_done = dbusy_reg && (dcnt_reg == '0);
    assign sts.sqrt_done = sbusy_reg && (sb_reg == '0);
    assign sts.sd_zero = (sd_reg[di] == '0);

    always_comb
    begin
        if (sd_reg[di] == '0)
        begin
            norm = dev_reg[32] ? 32'sh8000_0000
                               : ((dev_reg == '0) ? 32'sd0 : 32'sh7FFF_FFFF);
        end
        else if (dneg_reg)
        begin
            norm = (dq_reg > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-dq_reg);
        end
        else
        begin
            norm = (dq_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq_reg[31:0];
        end
    end
endmodule

/* design/zs_ctrl.sv */
// ---------------------------------------------------------------------------
// zs_ctrl
// Command sequencer: training writes, two-pass fit and normalise.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "zscore_standardizer_core_macros.svh"
module zs_ctrl #(
    parameter int DIMS = 8,
    parameter int MAX_POINTS = 1024,
    parameter int CW = 17,
    parameter int AW = 13
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                cmd,
    input  logic                      cfg_we,
    input  logic [3:0]                cfg_data,
    input  zs_pkg::sts_t              sts,
    output zs_pkg::ctl_t              ctl,
    output logic [$clog2(DIMS+1)-1:0] dim,
    output logic [CW-1:0]             n,
    output logic [AW-1:0]             addr,
    output logic                      we,
    output logic                      busy,
    output logic                      done,
    output logic [2:0]                status,
    output logic                      use_norm
);
    localparam int DCW = $clog2(DIMS + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_SUM_RD = 4'd1, S_SUM = 4'd2, S_MDIV = 4'd3,
                           S_MWR = 4'd4, S_SQ_RD = 4'd5, S_SQ_SUB = 4'd6, S_SQ_MUL = 4'd7,
                           S_SQ_ADD = 4'd8, S_VDIV = 4'd9, S_SQRT = 4'd10, S_SDWR = 4'd11,
                           S_NDIV = 4'd12, S_DONE = 4'd13, S_PRE = 4'd14;

    logic [3:0]     st_reg, st_next;
    logic [DCW-1:0] nd_reg, dc_reg, fd_reg;
    logic [CW-1:0]  pc_reg, p_reg;
    logic           fit_reg;
    logic [2:0]     stat_reg;
    logic           done_reg, usen_reg;
    logic [3:0]     cv;

    assign busy = (st_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign status = stat_reg;
    assign use_norm = usen_reg;
    assign n = pc_reg;
    assign dim = (st_reg == S_IDLE && !done_reg) ? dc_reg : fd_reg;
    assign cv = (cfg_data == 4'd0) ? 4'd1 : ((32'(cfg_data) > DIMS) ? 4'(DIMS) : cfg_data);

    always_comb
    begin
        logic [AW+CW-1:0] a;
        if (st_reg != S_IDLE)
            a = (AW+CW)'(32'(p_reg) * DIMS + 32'(fd_reg));
        else if (fit_reg)
            a = '0;
        else
            a = (AW+CW)'(32'(pc_reg) * DIMS + 32'(dc_reg));
        addr = a[AW-1:0];
    end

    always_comb
    begin
        ctl.op = zs_pkg::OP_NONE;
        we = 1'b0;
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (start && !done_reg && cmd == zs_pkg::CMD_TRAIN
                        && (fit_reg || 32'(pc_reg) < MAX_POINTS))
                begin
                    we = 1'b1;
                end
            end
            S_PRE:    begin ctl.op = zs_pkg::OP_SUM_CLR; st_next = S_SUM_RD; end
            S_SUM_RD: st_next = S_SUM;
            S_SUM:
            begin
                ctl.op = zs_pkg::OP_SUM_ADD;
                st_next = (p_reg == pc_reg - CW'(1)) ? S_MDIV : S_SUM_RD;
            end
            S_MDIV:   begin ctl.op = zs_pkg::OP_DIV_START; st_next = S_MWR; end
            S_MWR:
            begin
                ctl.op = zs_pkg::OP_DIV_STEP;
                if (sts.div_done)
                begin
                    ctl.op = zs_pkg::OP_MEAN_WR;
                    st_next = S_SQ_RD;
                end
            end
            S_SQ_RD:  st_next = S_SQ_SUB;
            S_SQ_SUB: begin ctl.op = zs_pkg::OP_SQ_MUL; st_next = S_SQ_MUL; end
            S_SQ_MUL: st_next = S_SQ_ADD;
            S_SQ_ADD:
            begin
                ctl.op = zs_pkg::OP_SQ_ADD;
                st_next = (p_reg == pc_reg - CW'(1)) ? S_VDIV : S_SQ_RD;
            end
            S_VDIV:   begin ctl.op = zs_pkg::OP_VAR_START; st_next = S_SQRT; end
            S_SQRT:
            begin
                ctl.op = zs_pkg::OP_DIV_STEP;
                if (sts.div_done)
                begin
                    ctl.op = zs_pkg::OP_SQRT_START;
                    st_next = S_SDWR;
                end
            end
            S_SDWR:
            begin
                ctl.op = zs_pkg::OP_SQRT_STEP;
                if (sts.sqrt_done)
                begin
                    ctl.op = zs_pkg::OP_SD_WR;
                    st_next = (fd_reg == nd_reg - DCW'(1)) ? S_DONE : S_PRE;
                end
            end
            S_NDIV:
            begin
                ctl.op = zs_pkg::OP_DIV_STEP;
                if (sts.div_done)
                begin
                    st_next = S_DONE;
                end
            end
            S_DONE:   st_next = S_IDLE;
            default:  st_next = S_IDLE;
        endcase
        if (st_reg == S_IDLE && start && !done_reg && cmd == zs_pkg::CMD_NORM && fit_reg)
        begin
            ctl.op = zs_pkg::OP_NORM_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            nd_reg <= DCW'((DIMS < 8) ? DIMS : 8);
            dc_reg <= '0;
            fd_reg <= '0;
            pc_reg <= '0;
            p_reg <= '0;
            fit_reg <= 1'b0;
            stat_reg <= zs_pkg::ST_OK;
            done_reg <= 1'b0;
            usen_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            st_reg <= st_next;
            if (st_reg == S_SUM || st_reg == S_SQ_ADD)
            begin
                p_reg <= (p_reg == pc_reg - CW'(1)) ? '0 : p_reg + CW'(1);
            end
            if (st_reg == S_SDWR && sts.sqrt_done)
            begin
                fd_reg <= fd_reg + DCW'(1);
                if (fd_reg == nd_reg - DCW'(1))
                begin
                    fit_reg <= 1'b1;
                end
            end
            if (st_reg == S_DONE)
            begin
                done_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                nd_reg <= DCW'(cv);
                pc_reg <= '0;
                dc_reg <= '0;
                fit_reg <= 1'b0;
            end
            else if (st_reg == S_IDLE && start && !done_reg)
            begin
                usen_reg <= 1'b0;
                unique case (cmd)
                    zs_pkg::CMD_TRAIN:
                    begin
                        if (fit_reg)
                        begin
                            fit_reg <= 1'b0;
                            pc_reg <= '0;
                            dc_reg <= (nd_reg == DCW'(1)) ? '0 : DCW'(1);
                            if (nd_reg == DCW'(1)) pc_reg <= CW'(1);
                        end
                        else if (32'(pc_reg) >= MAX_POINTS)
                        begin
                            stat_reg <= zs_pkg::ST_FULL;
                            done_reg <= 1'b1;
                        end
                        else if (dc_reg + DCW'(1) >= nd_reg)
                        begin
                            dc_reg <= '0;
                            pc_reg <= pc_reg + CW'(1);
                        end
                        else
                        begin
                            dc_reg <= dc_reg + DCW'(1);
                        end
                    end
                    zs_pkg::CMD_FINISH:
                    begin
                        dc_reg <= '0;
                        stat_reg <= zs_pkg::ST_OK;
                        if (pc_reg < CW'(2))
                        begin
                            fit_reg <= 1'b0;
                            stat_reg <= zs_pkg::ST_FEW;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            fit_reg <= 1'b0;
                            fd_reg <= '0;
                            p_reg <= '0;
                            st_reg <= S_PRE;
                        end
                    end
                    zs_pkg::CMD_NORM:
                    begin
                        if (!fit_reg)
                        begin
                            stat_reg <= zs_pkg::ST_UNFIT;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            fd_reg <= dc_reg;
                            dc_reg <= (dc_reg + DCW'(1) >= nd_reg) ? '0 : dc_reg + DCW'(1);
                            usen_reg <= 1'b1;
                            if (sts.sd_zero)
                            begin
                                stat_reg <= zs_pkg::ST_ZERO;
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                stat_reg <= zs_pkg::ST_OK;
                                st_reg <= S_NDIV;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    `ZS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `ZS_ASSERT_IMPL(a_busy_done, clk, rst_n, done_reg, busy)
    `ZS_ASSERT_IMPL(a_dim_range, clk, rst_n, 1'b1, dc_reg < nd_reg)
    `ZS_ASSERT_IMPL(a_fit_pts, clk, rst_n, fit_reg, pc_reg >= CW'(2))
endmodule

/* design/zscore_standardizer_core.sv */
// ---------------------------------------------------------------------------
// zscore_standardizer_core
// Z-score standardiser top level: store, controller and datapath.
// ---------------------------------------------------------------------------
// Usage: pulse start with cmd/value while busy is low; the transaction is
// taken at that edge. cmd 0 trains one element (no result unless the
// store is full: status 1). cmd 1 finishes the fit (under two points:
// status 2): per dimension one summing pass over the stored points, a
// 64-step divider, a squared-deviation pass, a second 64-step divide and
// a 32-step square root. cmd 2 normalises one value with the radix-2
// divider (unfitted: status 3); zero stddev answers without a divide,
// with status 4. Results appear for one cycle with done high; the
// receiver cannot stall, so busy covers that cycle. Writing cfg_we loads
// num_dims (clamped to 1..DIMS) and starts a new training set. Reset clears
// counters, tables and the fitted flag; the sample store needs no clearing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module zscore_standardizer_core #(
    parameter int DIMS = 8,
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_data,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic [2:0]         result_dim,
    output logic [2:0]         status
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(DIMS * MAX_POINTS);

    zs_pkg::ctl_t               ctl;
    zs_pkg::sts_t               sts;
    logic [$clog2(DIMS+1)-1:0]  dim;
    logic [CW-1:0]              n;
    logic [AW-1:0]              addr;
    logic                       we;
    logic                       use_norm;
    logic [31:0]                rdata;
    logic signed [31:0]         norm;

    zs_ram #(.WIDTH(32), .DEPTH(DIMS * MAX_POINTS)) u_store (
        .clk(clk), .we(we), .addr(addr), .wdata(value), .rdata(rdata)
    );

    zs_ctrl #(.DIMS(DIMS), .MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .sts(sts), .ctl(ctl), .dim(dim), .n(n), .addr(addr),
        .we(we), .busy(busy), .done(done), .status(status), .use_norm(use_norm)
    );

    zs_datapath #(.DIMS(DIMS), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .dim(dim), .n(n), .sample(rdata),
        .value(value), .sts(sts), .norm(norm)
    );

    assign result_value = use_norm ? norm : 32'sd0;
    assign result_dim = use_norm ? 3'(dim) : 3'd0;
endmodule

/* tb/sv/tb_zscore_standardizer_core.sv */
// ---------------------------------------------------------------------------
// tb_zscore_standardizer_core
// Self-checking bench for the z-score standardiser: directed corner cases,
// a store-full run, an accumulator-saturation run, then random training
// sets, fits and normalisations, every result checked by a transaction-level predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
    logic [31:0] val;
    logic [2:0]  dim;
    logic [2:0]  st;
} zs_result_t;

class zscore_scoreboard;
    localparam int NDIM = 8;
    localparam int NPTS = 1024;
    localparam int FBITS = 16;

    logic [31:0]        samples [NDIM*NPTS];
    logic signed [31:0] mean_tab [NDIM];
    logic [31:0]        sd_tab [NDIM];
    int                 pcount;
    int                 dcount;
    int                 ndims;
    bit                 fitted;
    zs_result_t         pending [$];
    int                 errors;

    function new();
        for (int i = 0; i < NDIM; i++)
        begin
            mean_tab[i] = '0;
            sd_tab[i] = '0;
        end
        pcount = 0;
        dcount = 0;
        ndims = 8;
        fitted = 0;
        errors = 0;
    endfunction

    function void set_dims(logic [3:0] v);
        ndims = (v < 1) ? 1 : ((v > NDIM) ? NDIM : int'(v));
        pcount = 0;
        dcount = 0;
        fitted = 0;
    endfunction

    function logic [31:0] root64(logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if ({32'd0, t} * {32'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    function void fit_stats();
        longint      sum;
        longint      mu;
        longint      dv;
        logic [63:0] mg;
        logic [64:0] acc;
        for (int d = 0; d < ndims; d++)
        begin
            sum = 0;
            for (int p = 0; p < pcount; p++)
                sum += longint'($signed(samples[p*NDIM + d]));
            mu = sum / pcount;
            mean_tab[d] = mu[31:0];
            acc = '0;
            for (int p = 0; p < pcount; p++)
            begin
                dv = longint'($signed(samples[p*NDIM + d])) - mu;
                mg = (dv < 0) ? 64'(-dv) : 64'(dv);
                acc = acc + mg * mg;
                if (acc[64])
                    acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            end
            sd_tab[d] = root64(acc[63:0] / 64'(pcount - 1));
        end
    endfunction

    function void note_input(logic [1:0] c, logic signed [31:0] v);
        int          d;
        longint      dv;
        logic [63:0] mg;
        logic [63:0] q;
        logic [31:0] res;
        case (c)
            zs_pkg::CMD_TRAIN:
            begin
                if (fitted)
                begin
                    pcount = 0;
                    dcount = 0;
                    fitted = 0;
                end
                if (pcount >= NPTS)
                    pending.push_back('{32'd0, 3'd0, zs_pkg::ST_FULL});
                else
                begin
                    samples[pcount*NDIM + dcount] = v;
                    dcount++;
                    if (dcount >= ndims)
                    begin
                        dcount = 0;
                        pcount++;
                    end
                end
            end
            zs_pkg::CMD_FINISH:
            begin
                dcount = 0;
                if (pcount < 2)
                begin
                    fitted = 0;
                    pending.push_back('{32'd0, 3'd0, zs_pkg::ST_FEW});
                end
                else
                begin
                    fit_stats();
                    fitted = 1;
                    pending.push_back('{32'd0, 3'd0, zs_pkg::ST_OK});
                end
            end
            zs_pkg::CMD_NORM:
            begin
                if (!fitted)
                    pending.push_back('{32'd0, 3'd0, zs_pkg::ST_UNFIT});
                else
                begin
                    d = dcount;
                    dcount = (d + 1 >= ndims) ? 0 : d + 1;
                    dv = longint'(v) - longint'(mean_tab[d]);
                    if (sd_tab[d] == 0)
                    begin
                        res = (dv > 0) ? 32'h7FFF_FFFF : ((dv < 0) ? 32'h8000_0000 : 32'd0);
                        pending.push_back('{res, 3'(d), zs_pkg::ST_ZERO});
                    end
                    else
                    begin
                        mg = (dv < 0) ? 64'(-dv) : 64'(dv);
                        q = (mg << FBITS) / {32'd0, sd_tab[d]};
                        if (dv < 0)
                            res = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
                        else
                            res = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
                        pending.push_back('{res, 3'(d), zs_pkg::ST_OK});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void check_result(logic [31:0] rv, logic [2:0] rd, logic [2:0] st);
        zs_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result: value %h dim %0d status %0d", rv, rd, st);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (rv !== e.val)
        begin
            $error("result_value: expected %h, actual %h", e.val, rv);
            errors++;
        end
        if (rd !== e.dim)
        begin
            $error("result_dim: expected %0d, actual %0d", e.dim, rd);
            errors++;
        end
        if (st !== e.st)
        begin
            $error("status: expected %0d, actual %0d", e.st, st);
            errors++;
        end
    endfunction
endclass

module tb_zscore_standardizer_core;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         QUIET_LIMIT = 400000;
    localparam int         RAND_ITEMS = 550;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic               cfg_we;
    logic [3:0]         cfg_data;
    logic               done;
    logic signed [31:0] result_value;
    logic [2:0]         result_dim;
    logic [2:0]         status;

    zscore_scoreboard sb;
    int               idle_pct;
    int               sent;
    int               quiet;
    int               cur_dims;

    zscore_standardizer_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .value(value),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .done(done),
        .result_value(result_value),
        .result_dim(result_dim),
        .status(status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result_value, result_dim, status);
            if (start && !busy)
                sb.note_input(cmd, value);
            if ((start && !busy) || done)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("[zscore_standardizer_core] ERROR");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(logic [1:0] c, logic [31:0] v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        while (busy)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        cmd = c;
        value = v;
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_dims(logic [3:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_data = v;
        sb.set_dims(v);
        cur_dims = sb.ndims;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick(int kind, logic [31:0] base);
        case (kind)
            0: return base;
            1: return base + 32'($signed($urandom_range(0, 2097152)) - 1048576);
            2: return $urandom;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic session();
        int          npts;
        int          kinds [8];
        logic [31:0] bases [8];
        if ($urandom_range(99) < 15)
            write_dims(4'($urandom_range(15)));
        for (int d = 0; d < 8; d++)
        begin
            kinds[d] = ($urandom_range(9) < 6) ? 1 : $urandom_range(3);
            bases[d] = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        end
        case ($urandom_range(19))
            0: npts = $urandom_range(1);
            1: npts = $urandom_range(20, 120);
            default: npts = $urandom_range(2, 8);
        endcase
        for (int p = 0; p < npts; p++)
            for (int d = 0; d < cur_dims; d++)
                send(zs_pkg::CMD_TRAIN, pick(kinds[d], bases[d]));
        if ($urandom_range(2) == 0)
            repeat ($urandom_range(0, cur_dims - 1))
                send(zs_pkg::CMD_TRAIN, $urandom);
        send(zs_pkg::CMD_FINISH, $urandom);
        repeat ($urandom_range(1, 12))
            send(zs_pkg::CMD_NORM, pick($urandom_range(3) == 0 ? 2 : 1, bases[sb.dcount]));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = zs_pkg::CMD_TRAIN;
        value = '0;
        cfg_we = 1'b0;
        cfg_data = 4'd0;
        quiet = 0;
        sent = 0;
        idle_pct = 0;
        cur_dims = 8;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        send(zs_pkg::CMD_NORM, 32'd1);
        send(zs_pkg::CMD_FINISH, 32'd0);
        send(CMD_SPARE, 32'hFFFF_FFFF);
        write_dims(4'd15);
        write_dims(4'd0);
        write_dims(4'd2);
        send(zs_pkg::CMD_TRAIN, 32'h7FFF_FFFF);
        send(zs_pkg::CMD_TRAIN, 32'd100);
        send(zs_pkg::CMD_FINISH, 32'd0);
        send(zs_pkg::CMD_TRAIN, 32'h8000_0000);
        send(zs_pkg::CMD_TRAIN, 32'd100);
        send(zs_pkg::CMD_TRAIN, 32'h0000_0000);
        send(zs_pkg::CMD_TRAIN, 32'd100);
        send(zs_pkg::CMD_TRAIN, 32'hFFFF_FFFF);
        send(zs_pkg::CMD_FINISH, 32'hFFFF_FFFF);
        send(zs_pkg::CMD_NORM, 32'h7FFF_FFFF);
        send(zs_pkg::CMD_NORM, 32'd100);
        send(zs_pkg::CMD_NORM, 32'h8000_0000);
        send(zs_pkg::CMD_NORM, 32'd200);
        send(zs_pkg::CMD_NORM, 32'd0);
        send(zs_pkg::CMD_NORM, 32'd0);
        send(zs_pkg::CMD_TRAIN, 32'd7);

        // store full
        write_dims(4'd1);
        for (int i = 0; i < 1026; i++)
            send(zs_pkg::CMD_TRAIN, (i % 7 == 0) ? 32'h8000_0000 : $urandom);
        send(zs_pkg::CMD_FINISH, 32'd0);
        send(zs_pkg::CMD_NORM, 32'h7FFF_FFFF);
        send(zs_pkg::CMD_NORM, 32'd0);

        // accumulator saturation and full dimension count
        write_dims(4'd8);
        for (int i = 0; i < 12 * 8; i++)
            send(zs_pkg::CMD_TRAIN, i[3] ? 32'h7FFF_FFFF : 32'h8000_0000);
        send(zs_pkg::CMD_FINISH, 32'd0);
        repeat (9) send(zs_pkg::CMD_NORM, $urandom);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            case (sent * 4 / RAND_ITEMS)
                1: idle_pct = 50;
                3: idle_pct = 6;
                default: idle_pct = 0;
            endcase
            if ($urandom_range(9) < 8)
                session();
            else
                send(2'($urandom_range(3)), $urandom);
        end

        drain();
        repeat (100) @(negedge clk);
        if (sb.errors == 0)
            $display("[zscore_standardizer_core] OK");
        else
            $display("[zscore_standardizer_core] ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/zs_pkg.sv
design/zs_ram.sv
design/zs_datapath.sv
design/zs_ctrl.sv
design/zscore_standardizer_core.sv
tb/sv/tb_zscore_standardizer_core.sv
